/* rtl/core/psf_pkg.sv */
package psf_pkg;

  localparam int MAX_PRIMES_DEF  = 64;
  localparam int VALUE_WIDTH_DEF = 16;
  // width of the candidate and prime fields on the stream ports
  localparam int FIELD_W         = 16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_DIV,
    ST_EMIT
  } state_t;

  // controls for the bit-serial remainder unit
  typedef struct packed {
    logic load;
    logic shift;
  } rem_ctrl_t;

  typedef struct packed {
    logic last;
    logic zero;
  } rem_stat_t;

  // controls for the prime table
  typedef struct packed {
    logic append;
  } tbl_ctrl_t;

endpackage

/* rtl/core/psf_rem.sv */
module psf_rem #(
  parameter int VALUE_WIDTH = psf_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  psf_pkg::rem_ctrl_t     ctrl,
  input  logic [VALUE_WIDTH-1:0] value,
  input  logic [VALUE_WIDTH-1:0] divisor,
  output psf_pkg::rem_stat_t     stat
);

  localparam int CW = $clog2(VALUE_WIDTH);

  logic [VALUE_WIDTH-1:0] shreg;
  logic [VALUE_WIDTH-1:0] rem;
  logic [VALUE_WIDTH-1:0] rem_next;
  logic [CW-1:0]          bitcnt;
  logic [VALUE_WIDTH:0]   r_shift;
  logic [VALUE_WIDTH:0]   r_diff;

  // one restoring division step per cycle while shift is set, msb of the dividend first
  always_comb begin
    r_shift = {rem, shreg[VALUE_WIDTH-1]};
    r_diff  = r_shift - {1'b0, divisor};
    if (r_shift >= {1'b0, divisor}) begin
      rem_next = r_diff[VALUE_WIDTH-1:0];
    end else begin
      rem_next = r_shift[VALUE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bitcnt <= '0;
    end else if (ctrl.load) begin
      bitcnt <= '0;
    end else if (ctrl.shift) begin
      bitcnt <= bitcnt + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      shreg <= value;
      rem   <= '0;
    end else if (ctrl.shift) begin
      shreg <= {shreg[VALUE_WIDTH-2:0], 1'b0};
      rem   <= rem_next;
    end
  end

  assign stat.last = (bitcnt == CW'(VALUE_WIDTH - 1));
  assign stat.zero = (rem_next == '0) && (divisor != '0);

endmodule

/* rtl/core/psf_table.sv */
module psf_table #(
  parameter int MAX_PRIMES  = psf_pkg::MAX_PRIMES_DEF,
  parameter int VALUE_WIDTH = psf_pkg::VALUE_WIDTH_DEF,
  parameter int AW          = (MAX_PRIMES > 1) ? $clog2(MAX_PRIMES) : 1,
  parameter int CNT_W       = $clog2(MAX_PRIMES + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  psf_pkg::tbl_ctrl_t     ctrl,
  input  logic [AW-1:0]          rd_addr,
  input  logic [VALUE_WIDTH-1:0] wr_data,
  output logic [VALUE_WIDTH-1:0] rd_data,
  output logic [CNT_W-1:0]       count
);

  logic [VALUE_WIDTH-1:0] mem [MAX_PRIMES];
  logic [AW-1:0]          wr_addr;

  assign wr_addr = AW'(count);

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    if (ctrl.append) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.append) begin
      count <= count + CNT_W'(1);
    end
  end

endmodule

/* rtl/core/prime_sieve_filter_chain.sv */
// Prime sieve: each candidate word on s_ is tested against every prime stored
// so far by one shared bit-serial remainder unit, one dividend bit per cycle.
// A candidate of 0 or 1 is taken and dropped. Otherwise it is accepted, then
// for each stored prime tested there is a table read followed by VALUE_WIDTH
// division steps (testing stops at the first prime that divides it), and a
// surviving word is then emitted. A survivor is stored unless the table
// already holds MAX_PRIMES entries, in which case it is sent with tuser
// (table_full) set. The finished word waits in an output register while the
// next candidate is taken; the emit cycle stalls while that register still
// holds a word that the sink has not taken.
module prime_sieve_filter_chain #(
  parameter int MAX_PRIMES  = psf_pkg::MAX_PRIMES_DEF,
  parameter int VALUE_WIDTH = psf_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [psf_pkg::FIELD_W-1:0]   s_tdata,  // [15:0] candidate
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [psf_pkg::FIELD_W-1:0]   m_tdata,  // [15:0] prime
  output logic                          m_tuser   // [0] table_full
);

  localparam int AW    = (MAX_PRIMES > 1) ? $clog2(MAX_PRIMES) : 1;
  localparam int CNT_W = $clog2(MAX_PRIMES + 1);
  localparam int EW    = (VALUE_WIDTH > psf_pkg::FIELD_W) ? VALUE_WIDTH : psf_pkg::FIELD_W;

  psf_pkg::state_t    state;
  psf_pkg::state_t    state_next;
  psf_pkg::rem_ctrl_t rem_ctrl;
  psf_pkg::rem_stat_t rem_stat;
  psf_pkg::tbl_ctrl_t tbl_ctrl;

  logic [VALUE_WIDTH-1:0] value;
  logic [VALUE_WIDTH-1:0] divisor;
  logic [AW-1:0]          idx;
  logic [CNT_W-1:0]       count;
  logic [EW-1:0]          cand_ext;
  logic [EW-1:0]          value_ext;
  logic                   accept;
  logic                   below_two;
  logic                   full;
  logic                   idx_last;
  logic                   out_free;
  logic                   emit;

  assign cand_ext  = EW'(s_tdata);
  assign value_ext = EW'(value);
  assign accept    = s_tvalid && s_tready;
  assign below_two = (cand_ext[VALUE_WIDTH-1:0] < VALUE_WIDTH'(2));
  assign full      = (count == CNT_W'(MAX_PRIMES));
  assign idx_last  = ((CNT_W + 1)'(idx) + (CNT_W + 1)'(1)) == (CNT_W + 1)'(count);
  assign out_free  = !m_tvalid || m_tready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      psf_pkg::ST_IDLE: begin
        if (accept && !below_two) begin
          state_next = (count == '0) ? psf_pkg::ST_EMIT : psf_pkg::ST_FETCH;
        end
      end
      psf_pkg::ST_FETCH: begin
        state_next = psf_pkg::ST_DIV;
      end
      psf_pkg::ST_DIV: begin
        if (rem_stat.last) begin
          if (rem_stat.zero) begin
            state_next = psf_pkg::ST_IDLE;
          end else if (idx_last) begin
            state_next = psf_pkg::ST_EMIT;
          end else begin
            state_next = psf_pkg::ST_FETCH;
          end
        end
      end
      psf_pkg::ST_EMIT: begin
        if (out_free) begin
          state_next = psf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = psf_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_tready       = 1'b0;
    rem_ctrl.load  = 1'b0;
    rem_ctrl.shift = 1'b0;
    emit           = 1'b0;
    case (state)
      psf_pkg::ST_IDLE:  s_tready       = 1'b1;
      psf_pkg::ST_FETCH: rem_ctrl.load  = 1'b1;
      psf_pkg::ST_DIV:   rem_ctrl.shift = 1'b1;
      psf_pkg::ST_EMIT:  emit           = out_free;
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  assign tbl_ctrl.append = emit && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= psf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (accept) begin
      idx <= '0;
    end else if (state == psf_pkg::ST_DIV && rem_stat.last && !idx_last) begin
      idx <= idx + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      value <= cand_ext[VALUE_WIDTH-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= value_ext[psf_pkg::FIELD_W-1:0];
      m_tuser <= full;
    end
  end

  psf_table #(
    .MAX_PRIMES  (MAX_PRIMES),
    .VALUE_WIDTH (VALUE_WIDTH),
    .AW          (AW),
    .CNT_W       (CNT_W)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (tbl_ctrl),
    .rd_addr (idx),
    .wr_data (value),
    .rd_data (divisor),
    .count   (count)
  );

  psf_rem #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_rem (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (rem_ctrl),
    .value   (value),
    .divisor (divisor),
    .stat    (rem_stat)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_PRIMES))
    else $error("prime count beyond table depth");

  a_idx_in_table: assert property (@(posedge clk) disable iff (rst)
    (state == psf_pkg::ST_FETCH || state == psf_pkg::ST_DIV) |->
      ((CNT_W + 1)'(idx) < (CNT_W + 1)'(count)))
    else $error("table read beyond stored primes");

  a_append_counts: assert property (@(posedge clk) disable iff (rst)
    tbl_ctrl.append |=> count == $past(count) + CNT_W'(1))
    else $error("stored prime not counted");

  a_word_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == psf_pkg::ST_EMIT)
    else $error("output word without emit");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state == psf_pkg::ST_DIV) |-> !s_tready)
    else $error("input taken while dividing");

endmodule

/* dv/tb_prime_sieve_filter_chain.sv */
`timescale 1ns / 1ps

module tb_prime_sieve_filter_chain;

  localparam int W           = psf_pkg::FIELD_W;
  localparam int TABLE_DEPTH = psf_pkg::MAX_PRIMES_DEF;
  localparam int VW          = psf_pkg::VALUE_WIDTH_DEF;
  localparam int WORDS_WANTED = 1900;
  localparam int CALM_TAIL    = 150;
  // worst case for one word: accept, every stored prime tested, emit
  localparam int DRAIN_CYCLES = 2 + TABLE_DEPTH * (VW + 1) + 32;
  localparam int CYCLE_LIMIT  = 8_000_000;

  typedef struct packed {
    logic [W-1:0] prime;
    logic         full;
  } sieve_word_t;

  typedef struct packed {
    logic [W-1:0] cand;
    bit           typed;
    bit           yields;
    logic [W-1:0] prime;
    bit           full;
  } sieve_row_t;

  logic         clk      = 1'b0;
  logic         rst      = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [W-1:0] s_tdata  = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [W-1:0] m_tdata;
  logic         m_tuser;

  prime_sieve_filter_chain DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #6 clk = ~clk;

  // predictor state
  logic [VW-1:0] kept_primes [TABLE_DEPTH];
  int unsigned   kept_count = 0;
  sieve_word_t   primes_due [$];

  int  error_count = 0;
  int  cycle_count = 0;
  bit  calm_tail   = 1'b0;
  bit  sender_calm = 1'b0;
  int  stall_left  = 0;
  int  run_left    = 0;
  sieve_word_t got_word;
  sieve_word_t due_word;

  // only entries below kept_count have been written
  function automatic bit sieve_judge(input logic [W-1:0] cand, output sieve_word_t word);
    logic [VW-1:0] value;
    value = cand[VW-1:0];
    word  = '0;
    if (value < 2) return 1'b0;
    for (int i = 0; i < kept_count; i++) begin
      if (kept_primes[i] != 0 && value % kept_primes[i] == 0) return 1'b0;
    end
    word.prime = W'(value);
    if (kept_count < TABLE_DEPTH) begin
      kept_primes[kept_count] = value;
      kept_count++;
      word.full = 1'b0;
    end else begin
      word.full = 1'b1;
    end
    return 1'b1;
  endfunction

  task automatic send_word(input logic [W-1:0] cand);
    int gap;
    gap = (!calm_tail && !sender_calm && $urandom_range(0, 2) == 0) ? $urandom_range(1, 14) : 0;
    @(negedge clk);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= cand;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (primes_due.size() != 0) @(posedge clk);
  endtask

  // receiver: stall bursts separated by ready stretches, some of them long
  always @(negedge clk) begin
    if (calm_tail) begin
      m_tready <= 1'b1;
    end else if (stall_left != 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else if (run_left != 0) begin
      m_tready <= 1'b1;
      run_left--;
    end else begin
      stall_left = $urandom_range(1, 14) - 1;
      run_left   = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 300) : $urandom_range(1, 20);
      m_tready <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_word.prime = m_tdata;
      got_word.full  = m_tuser;
      if (primes_due.size() == 0) begin
        $error("unexpected word: prime %0d table_full %0d", got_word.prime, got_word.full);
        error_count++;
      end else begin
        due_word = primes_due.pop_front();
        if (got_word.prime !== due_word.prime) begin
          $error("prime mismatch: expected %0d, actual %0d", due_word.prime, got_word.prime);
          error_count++;
        end
        if (got_word.full !== due_word.full) begin
          $error("table_full mismatch: expected %0d, actual %0d", due_word.full, got_word.full);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  sieve_row_t directed_rows [20] = '{
    '{16'd0,     1'b1, 1'b0, 16'd0, 1'b0},
    '{16'd1,     1'b1, 1'b0, 16'd0, 1'b0},
    '{16'd2,     1'b1, 1'b1, 16'd2, 1'b0},
    '{16'd2,     1'b1, 1'b0, 16'd0, 1'b0},  // repeat of a stored prime
    '{16'd65535, 1'b0, 1'b0, 16'd0, 1'b0},  // composite, factors not seen yet
    '{16'd3,     1'b0, 1'b0, 16'd0, 1'b0},
    '{16'd65534, 1'b1, 1'b0, 16'd0, 1'b0},
    '{16'd9,     1'b0, 1'b0, 16'd0, 1'b0},
    '{16'd25,    1'b0, 1'b0, 16'd0, 1'b0},  // out of order, survives
    '{16'd5,     1'b0, 1'b0, 16'd0, 1'b0},
    '{16'd125,   1'b0, 1'b0, 16'd0, 1'b0},
    '{16'd65521, 1'b0, 1'b0, 16'd0, 1'b0},
    '{16'd32768, 1'b1, 1'b0, 16'd0, 1'b0},
    '{16'd32767, 1'b0, 1'b0, 16'd0, 1'b0},
    '{16'd7,     1'b0, 1'b0, 16'd0, 1'b0},
    '{16'd49,    1'b0, 1'b0, 16'd0, 1'b0},
    '{16'h5555,  1'b0, 1'b0, 16'd0, 1'b0},
    '{16'hAAAB,  1'b0, 1'b0, 16'd0, 1'b0},
    '{16'd11,    1'b0, 1'b0, 16'd0, 1'b0},
    '{16'd13,    1'b0, 1'b0, 16'd0, 1'b0}
  };

  initial begin
    sieve_word_t word;
    bit          yields;
    int          counted;
    int          roll;
    int unsigned ascend_at;
    logic [W-1:0] cand;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].cand);
      yields = sieve_judge(directed_rows[i].cand, word);
      if (directed_rows[i].typed) begin
        yields     = directed_rows[i].yields;
        word.prime = directed_rows[i].prime;
        word.full  = directed_rows[i].full;
      end
      if (yields) primes_due.push_back(word);
    end

    hold_until_drained();

    // mostly an ascending run that fills the table and then overflows it
    ascend_at = 13;
    counted   = 0;
    while (counted < WORDS_WANTED) begin
      if (counted % 64 == 0) sender_calm = ($urandom_range(0, 3) == 0);
      if (counted % 400 == 399) hold_until_drained();
      calm_tail = (counted >= WORDS_WANTED - CALM_TAIL);
      roll = $urandom_range(0, 99);
      if (roll < 78) begin
        ascend_at += $urandom_range(1, 3);
        cand = ascend_at[W-1:0];
      end else if (roll < 88) begin
        cand = W'($urandom());
      end else if (roll < 92) begin
        cand = W'($urandom_range(0, 1));
      end else if (roll < 96 && kept_count != 0) begin
        cand = W'(kept_primes[$urandom_range(0, kept_count - 1)]);
      end else begin
        // broken sequence: jump back
        ascend_at = $urandom_range(2, ascend_at);
        cand = ascend_at[W-1:0];
      end
      send_word(cand);
      if (sieve_judge(cand, word)) primes_due.push_back(word);
      if (cand >= 2) counted++;
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (primes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (primes_due.size() != 0) begin
      $error("%0d expected words never arrived", primes_due.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/psf_pkg.sv
rtl/core/psf_rem.sv
rtl/core/psf_table.sv
rtl/core/prime_sieve_filter_chain.sv
dv/tb_prime_sieve_filter_chain.sv
